/* rtl/signed_date_difference_days_top_defines.svh */
// Assertion macros shared by the date difference RTL.
// Each use expects clk and rst in the enclosing module.
`ifndef SIGNED_DATE_DIFFERENCE_DAYS_TOP_DEFINES_SVH
`define SIGNED_DATE_DIFFERENCE_DAYS_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SDD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, off during reset.
`define SDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/sdd_pkg.sv */
// ----------------------------------------------------------------------------
// sdd_pkg: shared types and tables for the signed date difference block
// Field widths, calendar tables and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package sdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIFF_W  = 23;

  // floor(x / 100) == (x * RECIP100) >> RECIP_SH for every 14-bit x
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 19;
  localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'(5243);
  localparam int QUO_W = YEAR_W + RECIP_W - RECIP_SH;

  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
    logic               count_end_day;
  } date_pair_t;

  typedef struct packed {
    logic capture;
    logic step_quo;
    logic step_ord;
    logic step_dif;
    logic put;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  // Days in a month of a common year; zero for a month code with no meaning.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_W'(30);
      4'd2:                                        len = DAY_W'(28);
      default:                                     len = '0;
    endcase
    return len;
  endfunction

  // Days of a common year ahead of the first of month m.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

/* rtl/sdd_dates_if.sv */
// ----------------------------------------------------------------------------
// sdd_dates_if: input channel carrying a pair of dates
// Valid/ready handshake; one word is a date pair and the end-day flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdd_dates_if import sdd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   first_day;
  logic [MONTH_W-1:0] first_month;
  logic [YEAR_W-1:0]  first_year;
  logic [DAY_W-1:0]   second_day;
  logic [MONTH_W-1:0] second_month;
  logic [YEAR_W-1:0]  second_year;
  logic               count_end_day;

  modport source (
    output valid, first_day, first_month, first_year,
           second_day, second_month, second_year, count_end_day,
    input  ready
  );

  modport sink (
    input  valid, first_day, first_month, first_year,
           second_day, second_month, second_year, count_end_day,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/sdd_result_if.sv */
// ----------------------------------------------------------------------------
// sdd_result_if: output channel carrying the signed day difference
// Valid/ready handshake; one word is the difference and the bad date flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdd_result_if import sdd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] day_difference;
  logic                     bad_date;

  modport source (
    output valid, day_difference, bad_date,
    input  ready
  );

  modport sink (
    input  valid, day_difference, bad_date,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/sdd_ctrl.sv */
// ----------------------------------------------------------------------------
// sdd_ctrl: sequencer for the date difference datapath
// Walks one word through quotient, ordinal and difference steps, then
// hands it to the output register once that is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_date_difference_days_top_defines.svh"

module sdd_ctrl import sdd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    QUO  = 5'b00010,
    ORD  = 5'b00100,
    DIF  = 5'b01000,
    PUT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = QUO;
        end
      end
      QUO: begin
        cmd.step_quo = 1'b1;
        state_next   = ORD;
      end
      ORD: begin
        cmd.step_ord = 1'b1;
        state_next   = DIF;
      end
      DIF: begin
        cmd.step_dif = 1'b1;
        state_next   = PUT;
      end
      PUT: begin
        // hold until the previous result has left the output register
        if (sts.out_free) begin
          cmd.put    = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  `SDD_ASSERT_NEXT(a_capture_starts, cmd.capture, state == QUO)
  `SDD_ASSERT(a_put_when_free, cmd.put, sts.out_free)

endmodule

`default_nettype wire

/* rtl/sdd_dpath.sv */
// ----------------------------------------------------------------------------
// sdd_dpath: datapath for the signed date difference
// Captures a date pair, forms year quotients by reciprocal multiply, turns
// each date into an ordinal day number, and subtracts with sign.
// ----------------------------------------------------------------------------
`default_nettype none
`include "signed_date_difference_days_top_defines.svh"

module sdd_dpath import sdd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire date_pair_t               din,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [DIFF_W-1:0]      day_difference,
  output logic                          bad_date
);

  localparam int PROD_W = YEAR_W + RECIP_W;

  // floor(x / 100) for a 14-bit x
  function automatic logic [QUO_W-1:0] div100(input logic [YEAR_W-1:0] x);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(RECIP100);
    return prod[PROD_W-1:RECIP_SH];
  endfunction

  function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                   input logic [QUO_W-1:0]  qy);
    logic [YEAR_W:0] hund;
    hund = (YEAR_W+1)'(qy) * (YEAR_W+1)'(100);
    // divisible by 4, and either off a century or on a multiple of 400
    return (y[1:0] == 2'b00) && (((YEAR_W+1)'(y) != hund) || (qy[1:0] == 2'b00));
  endfunction

  function automatic logic date_ok(input logic [DAY_W-1:0]   d,
                                   input logic [MONTH_W-1:0] m,
                                   input logic [YEAR_W-1:0]  y,
                                   input logic               leap);
    logic [DAY_W-1:0] len;
    len = month_len(m) + DAY_W'((m == MONTH_FEB) && leap);
    return (y != '0) && (y <= YEAR_MAX) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
           (d != '0) && (d <= len);
  endfunction

  function automatic logic [DIFF_W-1:0] ordinal(input logic [DAY_W-1:0]   d,
                                                input logic [MONTH_W-1:0] m,
                                                input logic [YEAR_W-1:0]  p,
                                                input logic [QUO_W-1:0]   qp,
                                                input logic               leap);
    logic [DIFF_W-1:0] n;
    n = DIFF_W'(p) * DIFF_W'(365) + DIFF_W'(p >> 2) - DIFF_W'(qp) + DIFF_W'(qp >> 2);
    n = n + DIFF_W'(days_before(m)) + DIFF_W'((m > MONTH_FEB) && leap) + DIFF_W'(d);
    return n;
  endfunction

  // captured word
  date_pair_t dp;

  // quotient step
  logic [YEAR_W-1:0] p1, p2;
  logic [QUO_W-1:0]  qp1, qp2, qy1, qy2;

  // ordinal step
  logic [DIFF_W-1:0] n1, n2;
  logic              bad_ord;
  logic              end_ord;

  // difference step
  logic              neg;
  logic [DIFF_W-1:0] mag;
  logic              bad_dif;

  logic leap1, leap2;

  always_comb begin
    leap1 = is_leap(dp.first_year, qy1);
    leap2 = is_leap(dp.second_year, qy2);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dp <= din;
    end
    if (cmd.step_quo) begin
      p1  <= dp.first_year - YEAR_W'(1);
      p2  <= dp.second_year - YEAR_W'(1);
      qp1 <= div100(dp.first_year - YEAR_W'(1));
      qp2 <= div100(dp.second_year - YEAR_W'(1));
      qy1 <= div100(dp.first_year);
      qy2 <= div100(dp.second_year);
    end
    if (cmd.step_ord) begin
      n1      <= ordinal(dp.first_day, dp.first_month, p1, qp1, leap1);
      n2      <= ordinal(dp.second_day, dp.second_month, p2, qp2, leap2);
      bad_ord <= !date_ok(dp.first_day, dp.first_month, dp.first_year, leap1) ||
                 !date_ok(dp.second_day, dp.second_month, dp.second_year, leap2);
      end_ord <= dp.count_end_day;
    end
    if (cmd.step_dif) begin
      neg     <= n1 > n2;
      mag     <= ((n1 > n2) ? (n1 - n2) : (n2 - n1)) + DIFF_W'(end_ord);
      bad_dif <= bad_ord;
    end
    if (cmd.put) begin
      bad_date <= bad_dif;
      if (bad_dif) begin
        day_difference <= '0;
      end else if (neg) begin
        day_difference <= $signed(DIFF_W'('0) - mag);
      end else begin
        day_difference <= $signed(mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  `SDD_ASSERT(a_bad_gives_zero, out_valid && bad_date, day_difference == '0)
  `SDD_ASSERT_NEXT(a_later_first_nonzero, cmd.step_dif && (n1 > n2), mag != '0)
  `SDD_ASSERT_NEXT(a_put_shows_word, cmd.put, out_valid)

endmodule

`default_nettype wire

/* rtl/signed_date_difference_days_top.sv */
// ----------------------------------------------------------------------------
// signed_date_difference_days_top: signed day count between two dates
// Gregorian calendar, 4/100/400 leap rule; invalid dates flag bad_date.
// ----------------------------------------------------------------------------
//   channel  dir  word
//   dates    in   first/second day, month, year; count_end_day
//   result   out  day_difference (signed), bad_date
//
// An accepted word goes through capture, year quotients, ordinal day numbers,
// subtraction and output load in turn; the controller holds one word at a time.
// The output register lets a new word be taken while a result waits.
// A stalled result delays the output load step and so the next accept.
// Synchronous reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_date_difference_days_top import sdd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  sdd_dates_if.sink   dates,
  sdd_result_if.source result
);

  cmd_t       cmd;
  sts_t       sts;
  date_pair_t din;

  assign din.first_day     = dates.first_day;
  assign din.first_month   = dates.first_month;
  assign din.first_year    = dates.first_year;
  assign din.second_day    = dates.second_day;
  assign din.second_month  = dates.second_month;
  assign din.second_year   = dates.second_year;
  assign din.count_end_day = dates.count_end_day;

  sdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dates.valid),
    .in_ready (dates.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  sdd_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .din            (din),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .day_difference (result.day_difference),
    .bad_date       (result.bad_date)
  );

endmodule

`default_nettype wire
